/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, all sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds on the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons holds on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hdl/rgpc_pkg.sv */
// ----------------------------------------------------------------------------
// rgpc_pkg
// Widths, register indexes and reset values of the ray ground point classifier.
// ----------------------------------------------------------------------------
package rgpc_pkg;

    localparam int RADIUS_W  = 18;
    localparam int HEIGHT_W  = 16;
    localparam int TAG_W     = 17;
    localparam int SENSOR_W  = 14;
    localparam int TAN_W     = 16;
    localparam int THR_W     = 16;
    localparam int LHEIGHT_W = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_HEIGHT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_TANGENT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERAL_TANGENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_DIST    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECLASS_DIST    = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [SENSOR_W-1:0]   SENSOR_HEIGHT_RST   = 14'd2000;
    localparam logic [TAN_W-1:0]      LOCAL_TANGENT_RST   = 16'd358;
    localparam logic [TAN_W-1:0]      GENERAL_TANGENT_RST = 16'd215;
    localparam logic [THR_W-1:0]      MIN_HEIGHT_RST      = 16'd50;
    localparam logic [THR_W-1:0]      DIVIDER_DIST_RST    = 16'd10;
    localparam logic [RADIUS_W-1:0]   RECLASS_DIST_RST    = 18'd200;

    // The previous height starts out on the ground plane of the reset sensor height.
    localparam logic signed [LHEIGHT_W-1:0] LAST_HEIGHT_RST = -17'sd2000;

endpackage

/* hdl/ray_ground_point_classifier_top.sv */
// ----------------------------------------------------------------------------
// ray_ground_point_classifier_top
// Classifies the lidar points of one angular ray, sorted by radius, as ground
// or obstacle by comparing each point with the previous one and the ground plane.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                      Payload
//  -------   ----------------------------   -------------------------------------
//  input     in_valid / in_ready            radius, height, point_tag, ray_first
//  output    out_valid / out_ready          tag_out, is_ground
//  config    cfg_wr_en (no wait)            cfg_addr, cfg_wdata
//
// Each word passes an input register and then a result register before its
// result shows on the output, and one word is taken every cycle while the
// output is read.
// The rate is set by the classification stage: the stored previous point feeds
// the gap, two 16x18 multiplies and the window compares, and the verdict is written
// back in the same cycle for the next word.
// Reset clears both pipeline stages and loads the previous-point state with the
// start of a ray; configuration registers take their documented reset values.
// A stalled output holds the result register and, once the input register is
// also full, drops in_ready; no word is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_ground_point_classifier_top
    import rgpc_pkg::*;
#(
    parameter int TAN_FRAC_BITS = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [RADIUS_W-1:0]          radius,
    input  logic signed [HEIGHT_W-1:0]   height,
    input  logic [TAG_W-1:0]             point_tag,
    input  logic                         ray_first,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [TAG_W-1:0]             tag_out,
    output logic                         is_ground,

    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

    localparam int PROD_W = TAN_W + RADIUS_W;
    // Window arithmetic: a 17-bit signed centre plus or minus a 16-bit threshold.
    localparam int WIN_W = LHEIGHT_W + 2;
    localparam int GAP_W = RADIUS_W + 1;

    // Configuration registers.
    logic [SENSOR_W-1:0]  sensor_height_reg;
    logic [TAN_W-1:0]     local_tan_reg;
    logic [TAN_W-1:0]     general_tan_reg;
    logic [THR_W-1:0]     min_height_reg;
    logic [THR_W-1:0]     divider_dist_reg;
    logic [RADIUS_W-1:0]  reclass_dist_reg;

    // Input register.
    logic                        s1_valid_reg, s1_valid_next;
    logic [RADIUS_W-1:0]         s1_radius_reg;
    logic signed [HEIGHT_W-1:0]  s1_height_reg;
    logic [TAG_W-1:0]            s1_tag_reg;
    logic                        s1_first_reg;

    // Previous point of the current ray.
    logic [RADIUS_W-1:0]          last_radius_reg, last_radius_next;
    logic signed [LHEIGHT_W-1:0]  last_height_reg, last_height_next;
    logic                         last_ground_reg, last_ground_next;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic [TAG_W-1:0]   out_tag_reg;
    logic               out_ground_reg;

    logic s1_advance;
    logic take;
    logic in_take;

    logic [RADIUS_W-1:0]          eff_radius;
    logic signed [LHEIGHT_W-1:0]  eff_height;
    logic                         eff_ground;
    logic signed [LHEIGHT_W-1:0]  ground_level;
    logic signed [GAP_W-1:0]      gap;
    logic                         copy_verdict;
    logic                         far_gap;
    logic [PROD_W-1:0]            local_prod;
    logic [PROD_W-1:0]            general_prod;
    logic [PROD_W-1:0]            local_scaled;
    logic [PROD_W-1:0]            general_scaled;
    logic [THR_W-1:0]             local_sat;
    logic [THR_W-1:0]             local_thr;
    logic [THR_W-1:0]             general_thr;
    logic                         near_last;
    logic                         near_plane_general;
    logic                         near_plane_local;
    logic                         verdict;

    // True when h lies within centre - thr .. centre + thr, bounds included.
    function automatic logic in_window(
        input logic signed [HEIGHT_W-1:0]  h,
        input logic signed [LHEIGHT_W-1:0] centre,
        input logic [THR_W-1:0]            thr
    );
        logic signed [WIN_W-1:0] h_w;
        logic signed [WIN_W-1:0] c_w;
        logic signed [WIN_W-1:0] t_w;
        h_w = WIN_W'(h);
        c_w = WIN_W'(centre);
        t_w = $signed({{(WIN_W-THR_W){1'b0}}, thr});
        return (h_w <= c_w + t_w) && (h_w >= c_w - t_w);
    endfunction

    // ------------------------------------------------------------------
    // Handshake. The result register moves when it is empty or being read;
    // the input register moves whenever the result register can take it.
    // ------------------------------------------------------------------
    assign s1_advance = !out_valid_reg || out_ready;
    assign take       = s1_valid_reg && s1_advance;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_take    = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign tag_out   = out_tag_reg;
    assign is_ground = out_ground_reg;

    // ------------------------------------------------------------------
    // Classification. A ray start replaces the stored previous point with
    // the origin on the ground plane before the point is judged.
    // ------------------------------------------------------------------
    assign ground_level = LHEIGHT_W'(0) - $signed({{(LHEIGHT_W-SENSOR_W){1'b0}},
                                                    sensor_height_reg});
    assign eff_radius = s1_first_reg ? '0 : last_radius_reg;
    assign eff_height = s1_first_reg ? ground_level : last_height_reg;
    assign eff_ground = s1_first_reg ? 1'b0 : last_ground_reg;

    assign gap = $signed({1'b0, s1_radius_reg}) - $signed({1'b0, eff_radius});

    // An unsorted radius gives a negative gap, which also copies the verdict.
    assign copy_verdict = gap < $signed({{(GAP_W-THR_W){1'b0}}, divider_dist_reg});
    assign far_gap      = gap > $signed({1'b0, reclass_dist_reg});

    // When the gap is not copied it is non-negative and fits the radius width.
    assign local_prod     = PROD_W'(local_tan_reg) * PROD_W'(gap[RADIUS_W-1:0]);
    assign general_prod   = PROD_W'(general_tan_reg) * PROD_W'(s1_radius_reg);
    assign local_scaled   = local_prod >> TAN_FRAC_BITS;
    assign general_scaled = general_prod >> TAN_FRAC_BITS;

    // Thresholds saturate at the largest 16-bit value.
    assign local_sat   = (|local_scaled[PROD_W-1:THR_W]) ? '1 : local_scaled[THR_W-1:0];
    assign general_thr = (|general_scaled[PROD_W-1:THR_W]) ? '1
                                                           : general_scaled[THR_W-1:0];
    assign local_thr   = (local_sat < min_height_reg) ? min_height_reg : local_sat;

    assign near_last          = in_window(s1_height_reg, eff_height, local_thr);
    assign near_plane_general = in_window(s1_height_reg, ground_level, general_thr);
    assign near_plane_local   = in_window(s1_height_reg, ground_level, local_thr);

    always_comb
    begin
        if (copy_verdict)
        begin
            verdict = eff_ground;
        end
        else if (near_last)
        begin
            verdict = eff_ground || near_plane_general;
        end
        else
        begin
            // After a large gap the point may still lie on the ground plane.
            verdict = far_gap && near_plane_local;
        end
    end

    // ------------------------------------------------------------------
    // Next-state logic.
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next    = s1_valid_reg;
        out_valid_next   = out_valid_reg;
        last_radius_next = last_radius_reg;
        last_height_next = last_height_reg;
        last_ground_next = last_ground_reg;

        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (take)
        begin
            s1_valid_next = 1'b0;
        end

        if (take)
        begin
            out_valid_next   = 1'b1;
            last_radius_next = s1_radius_reg;
            last_height_next = LHEIGHT_W'(s1_height_reg);
            last_ground_next = verdict;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control and state registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_radius_reg <= '0;
            last_height_reg <= LAST_HEIGHT_RST;
            last_ground_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            last_radius_reg <= last_radius_next;
            last_height_reg <= last_height_next;
            last_ground_reg <= last_ground_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_radius_reg <= radius;
            s1_height_reg <= height;
            s1_tag_reg    <= point_tag;
            s1_first_reg  <= ray_first;
        end
        if (take)
        begin
            out_tag_reg    <= s1_tag_reg;
            out_ground_reg <= verdict;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers. Unknown indexes are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_height_reg <= SENSOR_HEIGHT_RST;
            local_tan_reg     <= LOCAL_TANGENT_RST;
            general_tan_reg   <= GENERAL_TANGENT_RST;
            min_height_reg    <= MIN_HEIGHT_RST;
            divider_dist_reg  <= DIVIDER_DIST_RST;
            reclass_dist_reg  <= RECLASS_DIST_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_SENSOR_HEIGHT:   sensor_height_reg <= cfg_wdata[SENSOR_W-1:0];
                CFG_LOCAL_TANGENT:   local_tan_reg     <= cfg_wdata[TAN_W-1:0];
                CFG_GENERAL_TANGENT: general_tan_reg   <= cfg_wdata[TAN_W-1:0];
                CFG_MIN_HEIGHT:      min_height_reg    <= cfg_wdata[THR_W-1:0];
                CFG_DIVIDER_DIST:    divider_dist_reg  <= cfg_wdata[THR_W-1:0];
                CFG_RECLASS_DIST:    reclass_dist_reg  <= cfg_wdata[RADIUS_W-1:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // Input back-pressure only comes from a full pipeline behind a stalled output.
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, !in_ready,
                    s1_valid_reg && out_valid_reg && !out_ready)
    // A classified point becomes the previous point of the next one.
    `ASSERT_NEXT(a_last_radius, clk, rst_n, take,
                 last_radius_reg == $past(s1_radius_reg) && out_valid_reg)
    // A point close behind the previous one inherits its verdict.
    `ASSERT_NEXT(a_copy_verdict, clk, rst_n, take && copy_verdict,
                 out_ground_reg == $past(eff_ground))

endmodule
